// File: sv/pfe_pkg.sv
// ----------------------------------------------------------------------------
// pfe_pkg
// Shared types, constants and helper functions for the pixel format expander.
// ----------------------------------------------------------------------------
`default_nettype none

package pfe_pkg;

  localparam int MAX_WIDTH    = 4096;
  localparam int PAL_ENTRIES  = 256;
  localparam int PAL_AW       = (PAL_ENTRIES > 1) ? $clog2(PAL_ENTRIES) : 1;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QUEUE_AW     = $clog2(QUEUE_DEPTH);
  localparam int CNT_W        = 13;

  // Configuration register indexes
  localparam logic [1:0] CFG_FORMAT = 2'd0;
  localparam logic [1:0] CFG_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_HEIGHT = 2'd2;
  localparam logic [1:0] CFG_UPR    = 2'd3;

  // Input command codes
  localparam logic CMD_PALETTE = 1'b0;
  localparam logic CMD_PIXELS  = 1'b1;

  typedef enum logic [2:0] {
    FMT_RGB32  = 3'd0,
    FMT_RGB555 = 3'd1,
    FMT_IDX8   = 3'd2,
    FMT_GRAY8  = 3'd3,
    FMT_IDX4   = 3'd4,
    FMT_IDX1   = 3'd5
  } fmt_t;

  typedef struct packed {
    logic        command;
    logic [31:0] data_word;
    logic [7:0]  palette_index;
    logic [23:0] palette_color;
  } in_item_t;

  typedef struct packed {
    logic [31:0] pixel_value;
    logic        last_of_item;
    logic        end_of_row;
    logic        end_of_frame;
  } out_item_t;

  typedef struct packed {
    logic [2:0]       pixel_format;
    logic [CNT_W-1:0] frame_width;
    logic [CNT_W-1:0] frame_height;
    logic [CNT_W-1:0] units_per_row;
  } cfg_t;

  // One classified unit or palette write, as queued for the back end
  typedef struct packed {
    logic        command;
    logic [2:0]  fmt;
    logic [31:0] data_word;
    logic [7:0]  palette_index;
    logic [23:0] palette_color;
    logic [3:0]  count;      // pixels to emit from this unit
    logic        ends_row;   // last emitted pixel closes the row
    logic        last_row;
  } job_t;

  function automatic logic [3:0] pixels_per_unit(input logic [2:0] fmt);
    case (fmt)
      FMT_IDX4: pixels_per_unit = 4'd2;
      FMT_IDX1: pixels_per_unit = 4'd8;
      default:  pixels_per_unit = 4'd1;
    endcase
  endfunction

  // floor(v * 255 / 32)
  function automatic logic [7:0] expand5(input logic [4:0] v);
    logic [12:0] prod;
    prod = ({v, 8'h00}) - {8'h00, v};
    expand5 = prod[12:5];
  endfunction

  function automatic logic pal_in_range(input logic [7:0] idx);
    pal_in_range = ({1'b0, idx} < 9'(PAL_ENTRIES));
  endfunction

endpackage

`default_nettype wire

// File: sv/pfe_front.sv
// ----------------------------------------------------------------------------
// pfe_front
// Accepts input transactions, tracks row position and classifies each unit.
// ----------------------------------------------------------------------------
`default_nettype none

module pfe_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire pfe_pkg::cfg_t    cfg,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire pfe_pkg::in_item_t in_item,
  input  wire logic             queue_full,
  output logic                  push,
  output pfe_pkg::job_t         job
);

  localparam int W = pfe_pkg::CNT_W;

  logic [W-1:0] column_r, column_nxt;
  logic [W-1:0] unit_r, unit_nxt;
  logic [W-1:0] row_r, row_nxt;

  logic [W-1:0] width_eff, height_eff, upr_eff;
  logic         last_unit, last_row;
  logic [3:0]   n_pix, k_pix;
  logic [W:0]   avail, col_end;
  logic         is_pix;

  assign in_ready = !queue_full;
  assign push     = in_valid && in_ready;
  assign is_pix   = (in_item.command == pfe_pkg::CMD_PIXELS);

  always_comb begin
    if (cfg.frame_width == '0) begin
      width_eff = W'(1);
    end else if (cfg.frame_width > W'(pfe_pkg::MAX_WIDTH)) begin
      width_eff = W'(pfe_pkg::MAX_WIDTH);
    end else begin
      width_eff = cfg.frame_width;
    end
    height_eff = (cfg.frame_height == '0) ? W'(1) : cfg.frame_height;
    upr_eff    = (cfg.units_per_row == '0) ? W'(1) : cfg.units_per_row;

    last_unit = ({1'b0, unit_r} + (W+1)'(1)) >= {1'b0, upr_eff};
    last_row  = ({1'b0, row_r} + (W+1)'(1)) >= {1'b0, height_eff};

    n_pix = pfe_pkg::pixels_per_unit(cfg.pixel_format);
    avail = (column_r < width_eff) ? ({1'b0, width_eff} - {1'b0, column_r}) : '0;
    k_pix = (avail >= (W+1)'(n_pix)) ? n_pix : avail[3:0];
    col_end = {1'b0, column_r} + (W+1)'(k_pix);

    job.command       = in_item.command;
    job.fmt           = cfg.pixel_format;
    job.data_word     = in_item.data_word;
    job.palette_index = in_item.palette_index;
    job.palette_color = in_item.palette_color;
    job.count         = is_pix ? k_pix : 4'd0;
    job.ends_row      = last_unit || (col_end == {1'b0, width_eff});
    job.last_row      = last_row;

    column_nxt = column_r;
    unit_nxt   = unit_r;
    row_nxt    = row_r;
    if (push && is_pix) begin
      if (last_unit) begin
        column_nxt = '0;
        unit_nxt   = '0;
        row_nxt    = last_row ? '0 : (row_r + W'(1));
      end else begin
        column_nxt = col_end[W-1:0];
        unit_nxt   = unit_r + W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_r <= '0;
      unit_r   <= '0;
      row_r    <= '0;
    end else begin
      column_r <= column_nxt;
      unit_r   <= unit_nxt;
      row_r    <= row_nxt;
    end
  end

endmodule

`default_nettype wire

// File: sv/pfe_queue.sv
// ----------------------------------------------------------------------------
// pfe_queue
// Short register queue between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module pfe_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire pfe_pkg::job_t push_job,
  input  wire logic          pop,
  output pfe_pkg::job_t      head,
  output logic               empty,
  output logic               full
);

  localparam int AW = pfe_pkg::QUEUE_AW;

  pfe_pkg::job_t entry_r [pfe_pkg::QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]   fill_r, fill_nxt;
  logic          do_push, do_pop;

  assign empty   = (fill_r == '0);
  assign full    = (fill_r == (AW+1)'(pfe_pkg::QUEUE_DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? (wr_ptr_r + AW'(1)) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? (rd_ptr_r + AW'(1)) : rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + (AW+1)'(1);
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - (AW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

`default_nettype wire

// File: sv/pfe_back.sv
// ----------------------------------------------------------------------------
// pfe_back
// Steps through queued units one pixel per cycle unless the output stalls,
// holds the palette and drives the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pfe_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire pfe_pkg::job_t head,
  input  wire logic          empty,
  output logic               pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output pfe_pkg::out_item_t out_item
);

  localparam int AW = pfe_pkg::PAL_AW;

  logic [23:0] pal_mem [pfe_pkg::PAL_ENTRIES];

  logic [2:0]  sub_r, sub_nxt;
  logic        out_valid_r;
  logic [31:0] direct_r;
  logic        use_pal_r, pal_ok_r;
  logic [23:0] pal_q_r;
  logic        last_r, eor_r, eof_r;

  logic        advance, active, is_pal, emit, last_pix, pal_we;
  logic [7:0]  rd_idx;
  logic [31:0] direct;
  logic        use_pal;
  logic [4:0]  w5_r, w5_g, w5_b;

  assign advance  = !out_valid_r || out_ready;
  assign active   = advance && !empty;
  assign is_pal   = (head.command == pfe_pkg::CMD_PALETTE);
  assign emit     = active && !is_pal && (head.count != 4'd0);
  assign last_pix = (({1'b0, sub_r}) + 4'd1) == head.count;
  assign pop      = active && (!emit || last_pix);
  assign pal_we   = active && is_pal && pfe_pkg::pal_in_range(head.palette_index);

  assign w5_r = head.data_word[4:0];
  assign w5_g = head.data_word[9:5];
  assign w5_b = head.data_word[14:10];

  // Decode the current pixel of the head unit
  always_comb begin
    direct  = head.data_word;
    use_pal = 1'b1;
    rd_idx  = head.data_word[7:0];
    unique case (pfe_pkg::fmt_t'(head.fmt)) inside
      pfe_pkg::FMT_RGB555: begin
        use_pal = 1'b0;
        direct  = {8'h00, pfe_pkg::expand5(w5_b), pfe_pkg::expand5(w5_g),
                   pfe_pkg::expand5(w5_r)};
      end
      pfe_pkg::FMT_IDX8, pfe_pkg::FMT_GRAY8: begin
        rd_idx = head.data_word[7:0];
      end
      pfe_pkg::FMT_IDX4: begin
        rd_idx = (sub_r == 3'd0) ? {4'h0, head.data_word[7:4]}
                                 : {4'h0, head.data_word[3:0]};
      end
      pfe_pkg::FMT_IDX1: begin
        rd_idx = {7'h00, head.data_word[{2'b00, 3'd7 - sub_r}]};
      end
      default: begin
        use_pal = 1'b0;
      end
    endcase
  end

  always_comb begin
    sub_nxt = sub_r;
    if (pop) begin
      sub_nxt = '0;
    end else if (emit) begin
      sub_nxt = sub_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      sub_r <= sub_nxt;
      if (advance) begin
        out_valid_r <= emit;
      end
    end
  end

  // Palette store and its registered read port
  always_ff @(posedge clk) begin
    if (pal_we) begin
      pal_mem[head.palette_index[AW-1:0]] <= head.palette_color;
    end
    if (emit) begin
      pal_q_r <= pal_mem[rd_idx[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      direct_r  <= direct;
      use_pal_r <= use_pal;
      pal_ok_r  <= pfe_pkg::pal_in_range(rd_idx);
      last_r    <= last_pix;
      eor_r     <= last_pix && head.ends_row;
      eof_r     <= last_pix && head.ends_row && head.last_row;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_item.pixel_value  = !use_pal_r ? direct_r
                               : (pal_ok_r ? {8'h00, pal_q_r} : 32'h0);
  assign out_item.last_of_item = last_r;
  assign out_item.end_of_row   = eor_r;
  assign out_item.end_of_frame = eof_r;

endmodule

`default_nettype wire

// File: sv/pixel_format_expand_to_rgb32.sv
// ----------------------------------------------------------------------------
// pixel_format_expand_to_rgb32
// Frame-buffer unit to 32-bit pixel converter with palette.
// ----------------------------------------------------------------------------
// Takes 32-bit, 16-bit (RGB555) or 8-bit source units of a frame and gives
// 32-bit pixels; 8, 4 and 1 bpp formats look up a 256-entry palette loaded
// through palette-write transactions on the same input channel (the user
// must write an entry before it is read; the block has no check for this;
// there is no clearing pass). A unit yields one pixel at 32/16/8 bpp, up
// to two at 4 bpp and up to eight at 1 bpp; padding units and palette
// writes yield none but still take a sequencer step. The back end emits
// one pixel per cycle unless the output stalls; palette read latency sits
// in the output register, so transactions of at most one pixel stream at
// one per clock. A four-entry queue decouples input acceptance from output
// stalls. The user ensures configuration is written only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module pixel_format_expand_to_rgb32 (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // configuration write port
  input  wire logic              cfg_write_en,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [12:0]       cfg_data,
  // source units and palette writes
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire pfe_pkg::in_item_t in_item,
  // pixel results
  output logic                   out_valid,
  input  wire logic              out_ready,
  output pfe_pkg::out_item_t     out_item
);

  // Configuration registers, raw as written; clamping happens in the front end
  pfe_pkg::cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_write_en) begin
      unique case (cfg_index)
        pfe_pkg::CFG_FORMAT: cfg_nxt.pixel_format  = cfg_data[2:0];
        pfe_pkg::CFG_WIDTH:  cfg_nxt.frame_width   = cfg_data;
        pfe_pkg::CFG_HEIGHT: cfg_nxt.frame_height  = cfg_data;
        pfe_pkg::CFG_UPR:    cfg_nxt.units_per_row = cfg_data;
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pixel_format  <= pfe_pkg::FMT_RGB32;
      cfg_r.frame_width   <= 13'd1;
      cfg_r.frame_height  <= 13'd1;
      cfg_r.units_per_row <= 13'd1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Front end: accept each transaction, classify it, advance row counters
  logic          push, queue_full, queue_empty, pop;
  pfe_pkg::job_t push_job, head_job;

  pfe_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .queue_full (queue_full),
    .push       (push),
    .job        (push_job)
  );

  // Hold classified jobs until the back end is free
  pfe_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head_job),
    .empty    (queue_empty),
    .full     (queue_full)
  );

  // Back end: apply palette writes, expand units into pixels
  pfe_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head_job),
    .empty     (queue_empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire
